// ===== hw/rtl/c2d_pkg.sv =====
`default_nettype none
package c2d_pkg;
  localparam int IMAGE_SIZE_D   = 28;
  localparam int KERNEL_SIZE_D  = 5;
  localparam int FILTER_COUNT_D = 20;
  localparam int FRAC_BITS_D    = 16;

  localparam logic [1:0] CMD_WEIGHT = 2'd0;
  localparam logic [1:0] CMD_BIAS   = 2'd1;
  localparam logic [1:0] CMD_PIXEL  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input beat
    logic wr_weight;
    logic wr_bias;
    logic wr_pixel;
    logic clr_acc;   // start a new filter
    logic mac;       // accumulate one tap
    logic fin;       // finish filter into output register
    logic adv_pos;   // step pixel position
  } c2d_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic win_full;
    logic tap_last;
    logic filt_last;
    logic out_busy;
  } c2d_sts_t;
endpackage
`default_nettype wire

// ===== hw/rtl/conv2d_5x5_relu_fixed.sv =====
// 5x5 single-channel convolution layer, 20 filters, ReLU, fixed point.
// Input channel (in_valid/in_stall): command 0 writes a weight, 1 a bias,
// 2 feeds one pixel in raster order; command 3 is dropped.
// Output channel (out_valid/out_stall): one beat per filter once a pixel
// completes a 5x5 window, filter 0 first, last_of_run on the final one.
// Each weight, bias or pixel beat is decoded before the next is taken. A
// window pixel keeps the input stalled until every filter has been run,
// even without output stalls: one shared multiplier walks the taps of each
// filter in turn, reading one weight and one line-buffer word per cycle.
// Reset clears the pixel position and output valid; weight, bias and line
// stores hold nothing defined until written.
// A stall on the output holds the result register; the filter walk waits
// for it and in_stall stays high until the last result of the run has been
// loaded into the output register, which may still be waiting to go out.
`default_nettype none
module conv2d_5x5_relu_fixed import c2d_pkg::*; #(
  parameter int IMAGE_SIZE   = IMAGE_SIZE_D,
  parameter int KERNEL_SIZE  = KERNEL_SIZE_D,
  parameter int FILTER_COUNT = FILTER_COUNT_D,
  parameter int FRAC_BITS    = FRAC_BITS_D
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_command,
  input  wire logic [4:0]         in_filter_sel,
  input  wire logic [2:0]         in_tap_row,
  input  wire logic [2:0]         in_tap_col,
  input  wire logic signed [31:0] in_data_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [4:0]              out_filter_index,
  output logic [4:0]              out_out_row,
  output logic [4:0]              out_out_col,
  output logic [30:0]             out_feature_value,
  output logic                    out_last_of_run
);
  c2d_cmd_t cmd;
  c2d_sts_t sts;

  c2d_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_command, .in_stall, .sts, .cmd
  );

  c2d_dp #(
    .IMAGE_SIZE(IMAGE_SIZE), .KERNEL_SIZE(KERNEL_SIZE),
    .FILTER_COUNT(FILTER_COUNT), .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk, .rst_n, .in_filter_sel, .in_tap_row, .in_tap_col, .in_data_value,
    .cmd, .sts, .out_valid, .out_stall, .out_filter_index, .out_out_row,
    .out_out_col, .out_feature_value, .out_last_of_run
  );
endmodule
`default_nettype wire

// ===== hw/rtl/c2d_ctrl.sv =====
`default_nettype none
module c2d_ctrl import c2d_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_command,
  output logic            in_stall,
  input  wire c2d_sts_t   sts,
  output c2d_cmd_t        cmd
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DEC  = 5'b00010,
    S_MAC  = 5'b00100,
    S_FIN  = 5'b01000,
    S_NEXT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] cmd_r;

  assign in_stall = (state_r != S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    if (state_r == S_IDLE && in_valid) cmd_r <= in_command;
  end

  // sequencing
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.wr_weight = (cmd_r == CMD_WEIGHT);
        cmd.wr_bias   = (cmd_r == CMD_BIAS);
        cmd.wr_pixel  = (cmd_r == CMD_PIXEL);
        if (cmd_r == CMD_PIXEL && sts.win_full) begin
          cmd.clr_acc = 1'b1;
          state_nxt = S_MAC;
        end else begin
          cmd.adv_pos = (cmd_r == CMD_PIXEL);
          state_nxt = S_IDLE;
        end
      end
      S_MAC: begin
        cmd.mac = 1'b1;
        if (sts.tap_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.fin = 1'b1;
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (sts.filt_last) begin
          cmd.adv_pos = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.clr_acc = 1'b1;
          state_nxt = S_MAC;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/c2d_dp.sv =====
`default_nettype none
module c2d_dp import c2d_pkg::*; #(
  parameter int IMAGE_SIZE   = IMAGE_SIZE_D,
  parameter int KERNEL_SIZE  = KERNEL_SIZE_D,
  parameter int FILTER_COUNT = FILTER_COUNT_D,
  parameter int FRAC_BITS    = FRAC_BITS_D
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [4:0]         in_filter_sel,
  input  wire logic [2:0]         in_tap_row,
  input  wire logic [2:0]         in_tap_col,
  input  wire logic signed [31:0] in_data_value,
  input  wire c2d_cmd_t           cmd,
  output c2d_sts_t                sts,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [4:0]              out_filter_index,
  output logic [4:0]              out_out_row,
  output logic [4:0]              out_out_col,
  output logic [30:0]             out_feature_value,
  output logic                    out_last_of_run
);
  localparam int TAPS  = KERNEL_SIZE * KERNEL_SIZE;
  localparam int WDEP  = FILTER_COUNT * TAPS;
  localparam int LDEP  = KERNEL_SIZE * IMAGE_SIZE;
  localparam int WAW   = $clog2(WDEP + 1);
  localparam int LAW   = $clog2(LDEP + 1);
  localparam int PW    = $clog2(IMAGE_SIZE + 1);
  localparam int KW    = $clog2(KERNEL_SIZE + 1);
  localparam int FW    = $clog2(FILTER_COUNT + 1);

  logic [31:0] wmem [WDEP];
  logic [31:0] bmem [FILTER_COUNT];
  logic [31:0] lmem [LDEP];

  logic [4:0]  fsel_r;
  logic [2:0]  tr_r, tc_r;
  logic [31:0] val_r;
  logic [PW-1:0] prow_r, pcol_r;
  logic [KW-1:0] pslot_r;       // prow mod kernel
  logic [KW-1:0] ky_r, kx_r;
  logic [KW-1:0] lslot_r;       // line slot of row ky
  logic [FW-1:0] f_r;
  logic [WAW-1:0] wa_r;         // running weight address
  logic          mac_v_r, mac_v2_r;
  logic [31:0]  pix_q, wt_q, bias_q;
  logic signed [63:0] prod_r;
  logic [31:0]  acc_r;
  logic         fin_pend_r;

  // input beat capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fsel_r <= in_filter_sel;
      tr_r   <= in_tap_row;
      tc_r   <= in_tap_col;
      val_r  <= in_data_value;
    end
  end

  // stores
  always_ff @(posedge clk) begin
    if (cmd.wr_weight && 32'(fsel_r) < 32'(FILTER_COUNT) && 32'(tr_r) < 32'(KERNEL_SIZE)
        && 32'(tc_r) < 32'(KERNEL_SIZE))
      wmem[WAW'(32'(fsel_r) * TAPS + 32'(tr_r) * KERNEL_SIZE + 32'(tc_r))] <= val_r;
    if (cmd.wr_bias && 32'(fsel_r) < 32'(FILTER_COUNT))
      bmem[fsel_r[FW-1:0]] <= val_r;
    if (cmd.wr_pixel)
      lmem[LAW'(32'(pslot_r) * IMAGE_SIZE + 32'(pcol_r))] <= val_r;
  end

  logic [PW-1:0] left_w, top_w;
  assign left_w = pcol_r - PW'(KERNEL_SIZE - 1);
  assign top_w  = prow_r - PW'(KERNEL_SIZE - 1);

  // registered memory reads
  always_ff @(posedge clk) begin
    pix_q  <= lmem[LAW'(32'(lslot_r) * IMAGE_SIZE + 32'(left_w) + 32'(kx_r))];
    wt_q   <= wmem[wa_r];
    bias_q <= bmem[f_r];
  end

  // window / filter counters and position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prow_r <= '0; pcol_r <= '0; pslot_r <= '0;
      mac_v_r <= 1'b0; mac_v2_r <= 1'b0;
      f_r <= '0; wa_r <= '0;
    end else begin
      mac_v_r  <= cmd.mac;
      mac_v2_r <= mac_v_r;
      if (cmd.clr_acc) begin
        ky_r <= '0; kx_r <= '0;
        lslot_r <= (32'(pslot_r) + 1 >= 32'(KERNEL_SIZE)) ? '0 : KW'(32'(pslot_r) + 1);
        if (cmd.wr_pixel) begin
          f_r <= '0; wa_r <= '0;
        end
      end
      if (cmd.mac) begin
        wa_r <= wa_r + 1'b1;
        if (32'(kx_r) == KERNEL_SIZE - 1) begin
          kx_r <= '0;
          ky_r <= ky_r + 1'b1;
          lslot_r <= (32'(lslot_r) == KERNEL_SIZE - 1) ? '0 : lslot_r + 1'b1;
        end else begin
          kx_r <= kx_r + 1'b1;
        end
      end
      if (cmd.fin) f_r <= f_r + 1'b1;
      if (cmd.adv_pos) begin
        if (32'(pcol_r) == IMAGE_SIZE - 1) begin
          pcol_r <= '0;
          if (32'(prow_r) == IMAGE_SIZE - 1) begin
            prow_r <= '0; pslot_r <= '0;
          end else begin
            prow_r <= prow_r + 1'b1;
            pslot_r <= (32'(pslot_r) == KERNEL_SIZE - 1) ? '0 : pslot_r + 1'b1;
          end
        end else begin
          pcol_r <= pcol_r + 1'b1;
        end
      end
    end
  end

  // multiply, then floor shift and accumulate
  always_ff @(posedge clk) begin
    prod_r <= $signed(pix_q) * $signed(wt_q);
    if (cmd.clr_acc) acc_r <= '0;
    else if (mac_v2_r) acc_r <= acc_r + prod_r[FRAC_BITS +: 32];
  end

  logic [31:0] sum_w;
  assign sum_w = acc_r + bias_q;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.fin) begin
      out_filter_index  <= 5'(f_r);
      out_out_row       <= 5'(top_w);
      out_out_col       <= 5'(left_w);
      out_feature_value <= sum_w[31] ? '0 : sum_w[30:0];
      out_last_of_run   <= (32'(f_r) == FILTER_COUNT - 1);
    end
  end

  // the last tap still drains through the read and product registers; fin waits for that
  always_ff @(posedge clk) begin
    if (!rst_n) fin_pend_r <= 1'b0;
    else fin_pend_r <= cmd.mac | mac_v_r;
  end

  assign sts.win_full  = (32'(prow_r) >= KERNEL_SIZE - 1) && (32'(pcol_r) >= KERNEL_SIZE - 1);
  assign sts.tap_last  = (32'(ky_r) == KERNEL_SIZE - 1) && (32'(kx_r) == KERNEL_SIZE - 1);
  assign sts.filt_last = (32'(f_r) == FILTER_COUNT);
  assign sts.out_busy  = (out_valid && out_stall) || fin_pend_r || mac_v2_r;
endmodule
`default_nettype wire

// ===== hw/rtl/c2d_checker.sv =====
`default_nettype none
module c2d_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [4:0]  out_filter_index,
  input wire logic [30:0] out_feature_value,
  input wire logic        out_last_of_run
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_feature_value))
    else $error("stalled result changed");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !(out_valid && !out_last_of_run))
    else $error("input taken during run");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_run && !out_stall |=> !out_valid || out_filter_index == 5'd0)
    else $error("result after end of run");
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run ##1 out_valid
    |-> out_filter_index == $past(out_filter_index) + 5'd1)
    else $error("filter order broken");
endmodule

bind conv2d_5x5_relu_fixed c2d_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
  .out_filter_index, .out_feature_value, .out_last_of_run
);
`default_nettype wire
